// ===== hdl/qvr_pkg.sv =====
// Shared widths, stage counts and limits of the quaternion vector rotator.
package qvr_pkg;

   localparam int COMP_W  = 16;                  // width of every input and output component
   localparam int PROD_W  = 2 * COMP_W;          // 16 x 16 product
   localparam int T_W     = PROD_W + 2;          // sum of three products
   localparam int NORM_W  = PROD_W + 1;          // sum of four squares
   localparam int RP_W    = T_W + COMP_W;        // t component times quaternion component
   localparam int R_W     = RP_W + 2;            // sum of four such products
   localparam int DEN_W   = NORM_W + 1;          // twice the squared norm
   localparam int QUO_W   = COMP_W + 1;          // rounded quotient magnitude
   localparam int DIV_STG = QUO_W;               // one quotient bit per stage
   localparam int PRE_STG = 5;                   // stages ahead of the divider
   localparam int NST     = PRE_STG + DIV_STG + 1;
   localparam int REQ_W   = 7 * COMP_W;
   localparam int RSP_W   = 3 * COMP_W;

   localparam logic [QUO_W-1:0] SAT_POS = QUO_W'(32767);
   localparam logic [QUO_W-1:0] SAT_NEG = QUO_W'(32768);

endpackage

// ===== hdl/quaternion_vector_rotate.sv =====
// Quaternion rotation of a 3D vector, fully pipelined with a restoring divider.
// Throughput: one word per cycle while the response side is not stalled; each stage advances on its own.
// The divider pipeline (one quotient bit per stage) sets the depth of the design.
// Stalls collapse bubbles: a stage takes new data whenever it is empty or its successor moves.
// Synchronous active-high reset clears the stage valid bits only; the data path is not reset.
module quaternion_vector_rotate (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // From bit 0 up: quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z (16 bits each).
   input  logic [qvr_pkg::REQ_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // From bit 0 up: rot_x, rot_y, rot_z (16 bits each).
   output logic [qvr_pkg::RSP_W-1:0]   rsp_tdata,
   // Bit 0: zero_quat_error.
   output logic                        rsp_tuser
);
   import qvr_pkg::*;

   // Stage valid bits and the advance chain. A stage loads when it is empty or when the
   // stage after it moves on, so a stalled response never forces the input to wait while
   // there are empty stages left in the pipe.
   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_in;
   logic [NST:0]   adv;

   always_comb begin
      adv[NST] = rsp_tready;
      for (int i = NST - 1; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
      vld_in[0] = req_tvalid;
      for (int i = 1; i < NST; i++) begin
         vld_in[i] = vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NST; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = vld_ff[NST-1];

   // Unpack the request word.
   logic signed [COMP_W-1:0] in_w, in_x, in_y, in_z, in_vx, in_vy, in_vz;
   assign in_w  = req_tdata[0*COMP_W +: COMP_W];
   assign in_x  = req_tdata[1*COMP_W +: COMP_W];
   assign in_y  = req_tdata[2*COMP_W +: COMP_W];
   assign in_z  = req_tdata[3*COMP_W +: COMP_W];
   assign in_vx = req_tdata[4*COMP_W +: COMP_W];
   assign in_vy = req_tdata[5*COMP_W +: COMP_W];
   assign in_vz = req_tdata[6*COMP_W +: COMP_W];

   // Stage 0: the four squares of the norm and the twelve products of t = q * (0, v).
   // Quaternion components are held as q[0..3] = w, x, y, z down the pipe.
   logic signed [PROD_W-1:0] sq0_ff [4];
   logic signed [PROD_W-1:0] tp0_ff [12];
   logic signed [COMP_W-1:0] q0_ff  [4];

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         q0_ff[0]  <= in_w;
         q0_ff[1]  <= in_x;
         q0_ff[2]  <= in_y;
         q0_ff[3]  <= in_z;
         sq0_ff[0] <= in_w * in_w;
         sq0_ff[1] <= in_x * in_x;
         sq0_ff[2] <= in_y * in_y;
         sq0_ff[3] <= in_z * in_z;
         tp0_ff[0]  <= in_x * in_vx;
         tp0_ff[1]  <= in_y * in_vy;
         tp0_ff[2]  <= in_z * in_vz;
         tp0_ff[3]  <= in_w * in_vx;
         tp0_ff[4]  <= in_y * in_vz;
         tp0_ff[5]  <= in_z * in_vy;
         tp0_ff[6]  <= in_w * in_vy;
         tp0_ff[7]  <= in_x * in_vz;
         tp0_ff[8]  <= in_z * in_vx;
         tp0_ff[9]  <= in_w * in_vz;
         tp0_ff[10] <= in_x * in_vy;
         tp0_ff[11] <= in_y * in_vx;
      end
   end

   // Stage 1: squared norm and the four components of t (tw, tx, ty, tz).
   logic [NORM_W-1:0]        n1_ff;
   logic signed [T_W-1:0]    t1_ff [4];
   logic signed [COMP_W-1:0] q1_ff [4];

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         q1_ff <= q0_ff;
         n1_ff <= NORM_W'(unsigned'(sq0_ff[0])) + NORM_W'(unsigned'(sq0_ff[1]))
                + NORM_W'(unsigned'(sq0_ff[2])) + NORM_W'(unsigned'(sq0_ff[3]));
         t1_ff[0] <= -T_W'(tp0_ff[0]) - T_W'(tp0_ff[1]) - T_W'(tp0_ff[2]);
         t1_ff[1] <=  T_W'(tp0_ff[3]) + T_W'(tp0_ff[4]) - T_W'(tp0_ff[5]);
         t1_ff[2] <=  T_W'(tp0_ff[6]) - T_W'(tp0_ff[7]) + T_W'(tp0_ff[8]);
         t1_ff[3] <=  T_W'(tp0_ff[9]) + T_W'(tp0_ff[10]) - T_W'(tp0_ff[11]);
      end
   end

   // Stage 2: the twelve products of the vector part of t * conj(q).
   logic signed [RP_W-1:0] rp2_ff [12];
   logic [NORM_W-1:0]      n2_ff;
   logic                   zero2_ff;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         n2_ff    <= n1_ff;
         zero2_ff <= (n1_ff == '0);
         // x row: tw*x, tx*w, ty*z, tz*y
         rp2_ff[0]  <= t1_ff[0] * q1_ff[1];
         rp2_ff[1]  <= t1_ff[1] * q1_ff[0];
         rp2_ff[2]  <= t1_ff[2] * q1_ff[3];
         rp2_ff[3]  <= t1_ff[3] * q1_ff[2];
         // y row: tw*y, tx*z, ty*w, tz*x
         rp2_ff[4]  <= t1_ff[0] * q1_ff[2];
         rp2_ff[5]  <= t1_ff[1] * q1_ff[3];
         rp2_ff[6]  <= t1_ff[2] * q1_ff[0];
         rp2_ff[7]  <= t1_ff[3] * q1_ff[1];
         // z row: tw*z, tx*y, ty*x, tz*w
         rp2_ff[8]  <= t1_ff[0] * q1_ff[3];
         rp2_ff[9]  <= t1_ff[1] * q1_ff[2];
         rp2_ff[10] <= t1_ff[2] * q1_ff[1];
         rp2_ff[11] <= t1_ff[3] * q1_ff[0];
      end
   end

   // Stage 3: unscaled rotated components.
   logic signed [R_W-1:0] r3_ff [3];
   logic [NORM_W-1:0]     n3_ff;
   logic                  zero3_ff;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         n3_ff    <= n2_ff;
         zero3_ff <= zero2_ff;
         r3_ff[0] <= -R_W'(rp2_ff[0]) + R_W'(rp2_ff[1]) - R_W'(rp2_ff[2])  + R_W'(rp2_ff[3]);
         r3_ff[1] <= -R_W'(rp2_ff[4]) + R_W'(rp2_ff[5]) + R_W'(rp2_ff[6])  - R_W'(rp2_ff[7]);
         r3_ff[2] <= -R_W'(rp2_ff[8]) - R_W'(rp2_ff[9]) + R_W'(rp2_ff[10]) + R_W'(rp2_ff[11]);
      end
   end

   // Divider pipe. Entry 0 is stage 4, which sets up round-to-nearest as
   // (2|r| + n) / (2n); entry k+1 is divider stage k, which settles quotient bit
   // QUO_W-1-k. The rotation keeps the magnitude below 2^16 times n, so 17 bits suffice.
   logic [R_W-1:0]   rem_ff  [DIV_STG+1][3];
   logic [QUO_W-1:0] quo_ff  [DIV_STG+1][3];
   logic             neg_ff  [DIV_STG+1][3];
   logic [DEN_W-1:0] den_ff  [DIV_STG+1];
   logic             zero_ff [DIV_STG+1];

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         den_ff[0]  <= {n3_ff, 1'b0};
         zero_ff[0] <= zero3_ff;
         for (int c = 0; c < 3; c++) begin
            neg_ff[0][c] <= r3_ff[c][R_W-1];
            rem_ff[0][c] <= (r3_ff[c][R_W-1] ? (R_W'(0) - unsigned'(r3_ff[c]))
                                             : unsigned'(r3_ff[c])) * 2
                          + R_W'(n3_ff);
            quo_ff[0][c] <= '0;
         end
      end
   end

   for (genvar k = 0; k < DIV_STG; k++) begin : g_div
      localparam int SH = QUO_W - 1 - k;
      logic [R_W-1:0] dsh;
      logic [R_W:0]   diff [3];

      assign dsh = R_W'(den_ff[k]) << SH;

      always_comb begin
         for (int c = 0; c < 3; c++) begin
            diff[c] = {1'b0, rem_ff[k][c]} - {1'b0, dsh};
         end
      end

      always_ff @(posedge clock) begin
         if (adv[PRE_STG + k]) begin
            den_ff[k+1]  <= den_ff[k];
            zero_ff[k+1] <= zero_ff[k];
            for (int c = 0; c < 3; c++) begin
               neg_ff[k+1][c] <= neg_ff[k][c];
               // A clear borrow bit means the shifted divisor fits.
               rem_ff[k+1][c] <= diff[c][R_W] ? rem_ff[k][c] : diff[c][R_W-1:0];
               quo_ff[k+1][c] <= quo_ff[k][c] | (QUO_W'(!diff[c][R_W]) << SH);
            end
         end
      end
   end

   // Output register: apply the sign, saturate to 16 bits, force zeros on a zero quaternion.
   logic [RSP_W-1:0] rsp_data_ff;
   logic [RSP_W-1:0] rsp_data_in;
   logic             rsp_err_ff;

   always_comb begin
      logic [QUO_W-1:0] mag;
      rsp_data_in = '0;
      for (int c = 0; c < 3; c++) begin
         if (neg_ff[DIV_STG][c]) begin
            mag = (quo_ff[DIV_STG][c] > SAT_NEG) ? SAT_NEG : quo_ff[DIV_STG][c];
            rsp_data_in[c*COMP_W +: COMP_W] = COMP_W'(QUO_W'(0) - mag);
         end else begin
            mag = (quo_ff[DIV_STG][c] > SAT_POS) ? SAT_POS : quo_ff[DIV_STG][c];
            rsp_data_in[c*COMP_W +: COMP_W] = COMP_W'(mag);
         end
      end
      if (zero_ff[DIV_STG]) begin
         rsp_data_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[NST-1]) begin
         rsp_data_ff <= rsp_data_in;
         rsp_err_ff  <= zero_ff[DIV_STG];
      end
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_err_ff;

   // An error word always carries a zero vector.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("error response carries a nonzero vector");

   // An accepted request word always lands in the first stage.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("accepted request word was dropped");

   // The input only waits when every stage holds a word.
   a_full_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> &vld_ff)
      else $error("input stalled while the pipeline has a bubble");

endmodule
